### sv/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg: shared types for the newest-wins k-way merge
// Item structs for both channels, the scan token passed along the cell row,
// and the configuration register indexes.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int unsigned KeyW = 64;
  localparam int unsigned ValW = 32;
  localparam int unsigned SrcW = 3;
  localparam int unsigned MaskW = 8;
  localparam int unsigned CntCfgW = 4;

  // configuration register indexes
  localparam logic CfgDropDeletes  = 1'b0;
  localparam logic CfgSourcesInUse = 1'b1;

  typedef struct packed {
    logic [SrcW-1:0] source;
    logic            end_of_source;
    logic [KeyW-1:0] record_key;
    logic            record_is_delete;
    logic [ValW-1:0] value_ref;
  } kwm_in_t;

  typedef struct packed {
    logic             emitted;
    logic [KeyW-1:0]  out_key;
    logic             out_is_delete;
    logic [ValW-1:0]  out_value_ref;
    logic [MaskW-1:0] consumed_mask;
    logic             merge_done;
  } kwm_out_t;

  // running minimum carried from cell to cell during a scan
  typedef struct packed {
    logic            go;   // token is in flight at this stage
    logic            any;  // a candidate has been picked
    logic [KeyW-1:0] key;
    logic [ValW-1:0] val;
    logic            del;
  } kwm_tok_t;

endpackage

### sv/kway_merge_newest_wins.sv
// ----------------------------------------------------------------------------
// kway_merge_newest_wins: newest-wins k-way merge of sorted record streams
// Control, configuration and result stage around a row of head cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_i): each item fills the head
//   of one source or marks that source exhausted. Source 0 is the newest.
//   Output channel (out_valid_o / out_stall_i / out_o): at most one item per
//   input item - the winning record with its consumed mask, or a done marker.
//   Config port: cfg_we_i writes drop_deletes (index 0) or sources_in_use
//   (index 1); write only while the block is idle.
// Sequence:
//   One item is worked on at a time. Accept, a decide state, then the scan
//   token walks the cell row one cell per cycle, then the result moves into
//   the pending register and on to the output register. An item that leaves
//   a live source without head gives no output. When every source in use is
//   exhausted and no head is left, a done marker goes to the result stage.
// Stall: a finished result waits in a pending register while the output
//   register is stalled; the next item is taken once the pending slot is free.
// Reset: all heads absent, no source exhausted, drop_deletes = 0,
//   sources_in_use = 2. Head payload is not cleared.
// ----------------------------------------------------------------------------
module kway_merge_newest_wins
  import kwm_pkg::*;
#(
  parameter int unsigned MAX_INPUTS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kwm_in_t            in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kwm_out_t           out_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CntCfgW-1:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_INPUTS + 1);
  localparam int unsigned CmpW = (CntW > CntCfgW) ? CntW : CntCfgW;
  localparam int unsigned SelW = ($clog2(MAX_INPUTS) > SrcW) ? $clog2(MAX_INPUTS) : SrcW;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StDecide = 2'd1;
  localparam logic [1:0] StScan   = 2'd2;

  logic [1:0]             state_d, state_q;
  logic                   drop_q;
  logic [CntCfgW-1:0]     siu_q;
  logic [MAX_INPUTS-1:0]  present_d, present_q;
  logic [MAX_INPUTS-1:0]  exh_d, exh_q;
  logic [MAX_INPUTS-1:0]  used, held, live, fill_en, last_mask;
  logic [CmpW-1:0]        siu_ext, n_eff;
  logic                   accept, launch;
  kwm_tok_t               tok_in, tok_last;
  kwm_out_t               res_d, res_q, out_q;
  logic                   pend_d, pend_q, out_vld_d, out_vld_q;
  logic [MaskW-1:0]       cmask;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= 1'b0;
      siu_q  <= CntCfgW'(2);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgDropDeletes) begin
        drop_q <= cfg_wdata_i[0];
      end else begin
        siu_q <= cfg_wdata_i;
      end
    end
  end

  // effective source count: 0 acts as 1, saturates at MAX_INPUTS
  assign siu_ext = CmpW'(siu_q);
  always_comb begin
    if (siu_ext == '0) begin
      n_eff = CmpW'(1);
    end else if (siu_ext > CmpW'(MAX_INPUTS)) begin
      n_eff = CmpW'(MAX_INPUTS);
    end else begin
      n_eff = siu_ext;
    end
  end

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle) || pend_q;

  for (genvar j = 0; j < MAX_INPUTS; j++) begin : g_src
    assign used[j] = CmpW'(j) < n_eff;
    assign fill_en[j] = accept && !in_i.end_of_source && used[j] && !exh_q[j]
                        && (SelW'(in_i.source) == SelW'(j));
  end

  assign held = present_q & used;
  assign live = used & ~exh_q;

  // consumed mask onto the fixed-width output field
  for (genvar b = 0; b < MaskW; b++) begin : g_cmask
    if (b < MAX_INPUTS) begin : g_on
      assign cmask[b] = last_mask[b];
    end else begin : g_off
      assign cmask[b] = 1'b0;
    end
  end

  assign launch = (state_q == StDecide) && (held != '0) && ((live & ~held) == '0);

  always_comb begin
    tok_in     = '0;
    tok_in.go  = launch;
  end

  kwm_row #(
    .NumSrc (MAX_INPUTS)
  ) u_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fill_en_i  (fill_en),
    .fill_key_i (in_i.record_key),
    .fill_val_i (in_i.value_ref),
    .fill_del_i (in_i.record_is_delete),
    .held_i     (held),
    .tok_i      (tok_in),
    .tok_o      (tok_last),
    .mask_o     (last_mask)
  );

  // sequencing and head bookkeeping
  always_comb begin
    state_d   = state_q;
    present_d = present_q;
    exh_d     = exh_q;
    pend_d    = pend_q;
    res_d     = res_q;
    out_vld_d = out_vld_q;

    // result stage: pending result moves out once the output slot is free
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
    if (pend_q && (!out_vld_q || !out_stall_i)) begin
      pend_d    = 1'b0;
      out_vld_d = 1'b1;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StDecide;
          if (in_i.end_of_source) begin
            for (int unsigned j = 0; j < MAX_INPUTS; j++) begin
              if (used[j] && (SelW'(in_i.source) == SelW'(j))) begin
                exh_d[j] = 1'b1;
              end
            end
          end else begin
            present_d = present_q | fill_en;
          end
        end
      end
      StDecide: begin
        if ((held == '0) && (live == '0)) begin
          // every source in use is finished
          res_d            = '0;
          res_d.merge_done = 1'b1;
          pend_d           = 1'b1;
          state_d          = StIdle;
        end else if (launch) begin
          state_d = StScan;
        end else begin
          state_d = StIdle;
        end
      end
      StScan: begin
        if (tok_last.go) begin
          res_d.emitted       = !(drop_q && tok_last.del);
          res_d.out_key       = tok_last.key;
          res_d.out_is_delete = tok_last.del;
          res_d.out_value_ref = tok_last.val;
          res_d.consumed_mask = cmask;
          res_d.merge_done    = 1'b0;
          pend_d              = 1'b1;
          present_d           = present_q & ~last_mask;
          state_d             = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      present_q <= '0;
      exh_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      exh_q     <= exh_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (pend_q && (!out_vld_q || !out_stall_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

### sv/kwm_cell.sv
// ----------------------------------------------------------------------------
// kwm_cell: one source head slot of the merge row
// Holds the head record of one source and folds it into the passing scan
// token: a smaller key takes over, an equal key joins the consumed mask.
// ----------------------------------------------------------------------------
module kwm_cell
  import kwm_pkg::*;
#(
  parameter int unsigned NumSrc = 8,
  parameter int unsigned Idx    = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fill_en_i,
  input  logic [KeyW-1:0]   fill_key_i,
  input  logic [ValW-1:0]   fill_val_i,
  input  logic              fill_del_i,
  input  logic              held_i,
  input  kwm_tok_t          tok_i,
  input  logic [NumSrc-1:0] mask_i,
  output kwm_tok_t          tok_o,
  output logic [NumSrc-1:0] mask_o
);

  logic [KeyW-1:0]   key_q;
  logic [ValW-1:0]   val_q;
  logic              del_q;
  logic              go_q;
  kwm_tok_t          tok_d, tok_q;
  logic [NumSrc-1:0] mask_d, mask_q;
  logic              take, same;

  always_ff @(posedge clk_i) begin
    if (fill_en_i) begin
      key_q <= fill_key_i;
      val_q <= fill_val_i;
      del_q <= fill_del_i;
    end
  end

  assign take = held_i && (!tok_i.any || (key_q < tok_i.key));
  assign same = held_i && tok_i.any && (key_q == tok_i.key);

  always_comb begin
    tok_d  = tok_i;
    mask_d = mask_i;
    if (take) begin
      tok_d.any = 1'b1;
      tok_d.key = key_q;
      tok_d.val = val_q;
      tok_d.del = del_q;
      mask_d    = '0;
      mask_d[Idx] = 1'b1;
    end else if (same) begin
      mask_d[Idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q <= 1'b0;
    end else begin
      go_q <= tok_i.go;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    mask_q <= mask_d;
  end

  always_comb begin
    tok_o    = tok_q;
    tok_o.go = go_q;
  end
  assign mask_o = mask_q;

endmodule

### sv/kwm_row.sv
// ----------------------------------------------------------------------------
// kwm_row: row of head cells
// Chains the cells so that a scan token moves one cell per cycle from
// source 0 up to the last source.
// ----------------------------------------------------------------------------
module kwm_row
  import kwm_pkg::*;
#(
  parameter int unsigned NumSrc = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [NumSrc-1:0] fill_en_i,
  input  logic [KeyW-1:0]   fill_key_i,
  input  logic [ValW-1:0]   fill_val_i,
  input  logic              fill_del_i,
  input  logic [NumSrc-1:0] held_i,
  input  kwm_tok_t          tok_i,
  output kwm_tok_t          tok_o,
  output logic [NumSrc-1:0] mask_o
);

  kwm_tok_t          tok_w  [NumSrc+1];
  logic [NumSrc-1:0] mask_w [NumSrc+1];

  assign tok_w[0]  = tok_i;
  assign mask_w[0] = '0;

  for (genvar j = 0; j < NumSrc; j++) begin : g_cell
    kwm_cell #(
      .NumSrc (NumSrc),
      .Idx    (j)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .fill_en_i  (fill_en_i[j]),
      .fill_key_i (fill_key_i),
      .fill_val_i (fill_val_i),
      .fill_del_i (fill_del_i),
      .held_i     (held_i[j]),
      .tok_i      (tok_w[j]),
      .mask_i     (mask_w[j]),
      .tok_o      (tok_w[j+1]),
      .mask_o     (mask_w[j+1])
    );
  end

  assign tok_o  = tok_w[NumSrc];
  assign mask_o = mask_w[NumSrc];

endmodule
